// ===== design/sacl_pkg.sv =====
`default_nettype none

package sacl_pkg;

  localparam int unsigned AddrW         = 32;
  localparam int unsigned TagW          = 32;
  localparam int unsigned IdxW          = 10;
  localparam int unsigned WayUsedW      = 3;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 4;
  localparam int unsigned ShiftW        = 5;
  localparam int unsigned WayCntW       = 5;

  localparam logic [CfgDataW-1:0] MaxOffsetBits = 4'd12;
  localparam logic [CfgDataW-1:0] MaxIndexBits  = 4'd10;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOffsetBits = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIndexBits  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWaysInUse  = 2'd2;

  localparam logic [CfgDataW-1:0] OffsetBitsRst = 4'd5;
  localparam logic [CfgDataW-1:0] IndexBitsRst  = 4'd6;
  localparam logic [CfgDataW-1:0] WaysInUseRst  = 4'd4;

  // request kinds
  localparam logic ReqRead  = 1'b0;
  localparam logic ReqWrite = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [AddrW-1:0] address;
  } sacl_req_t;

  typedef struct packed {
    logic                hit;
    logic                fetch_needed;
    logic                writeback_needed;
    logic [AddrW-1:0]    writeback_address;
    logic [WayUsedW-1:0] way_used;
  } sacl_rsp_t;

endpackage

`default_nettype wire

// ===== design/sacl_set_ram.sv =====
`default_nettype none

module sacl_set_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 64
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/sacl_way_cmp.sv =====
`default_nettype none

module sacl_way_cmp #(
  parameter int unsigned WayW  = 3,
  parameter int unsigned RankW = 3
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic                      step_i,
  input  wire logic [WayW-1:0]           way_i,
  input  wire logic                      valid_i,
  input  wire logic [sacl_pkg::TagW-1:0] tag_i,
  input  wire logic [RankW-1:0]          rank_i,
  input  wire logic [sacl_pkg::TagW-1:0] req_tag_i,
  output logic                           hit_o,
  output logic      [WayW-1:0]           hit_way_o,
  output logic      [WayW-1:0]           vic_way_o
);

  import sacl_pkg::*;

  logic             hit_q, hit_d;
  logic [WayW-1:0]  hit_way_q, hit_way_d;
  logic [WayW-1:0]  vic_way_q, vic_way_d;
  logic [RankW-1:0] vic_rank_q, vic_rank_d;

  // one way per step: tag match and running highest rank
  always_comb begin
    hit_d      = hit_q;
    hit_way_d  = hit_way_q;
    vic_way_d  = vic_way_q;
    vic_rank_d = vic_rank_q;
    if (start_i) begin
      hit_d      = 1'b0;
      hit_way_d  = '0;
      vic_way_d  = '0;
      vic_rank_d = '0;
    end else if (step_i) begin
      if (!hit_q && valid_i && (tag_i == req_tag_i)) begin
        hit_d     = 1'b1;
        hit_way_d = way_i;
      end
      if ((way_i == '0) || (rank_i > vic_rank_q)) begin
        vic_way_d  = way_i;
        vic_rank_d = rank_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_way_q  <= hit_way_d;
    vic_way_q  <= vic_way_d;
    vic_rank_q <= vic_rank_d;
  end

  assign hit_o     = hit_q;
  assign hit_way_o = hit_way_q;
  assign vic_way_o = vic_way_q;

endmodule

`default_nettype wire

// ===== design/set_assoc_writeback_cache_lru_core.sv =====
`default_nettype none

// per item: accepted in idle, the set index wrap when SETS is below 1024 and not a power of two,
//   a synchronous read of the set row, a scan over the effective ways, then the row update
// a new item is taken only once the result of the last one is registered; the way scan uses one
//   shared compare unit that visits one way per cycle, after the synchronous read of the set row
// reset: a clearing pass writes every set row before the first item is taken;
//   configuration writes are accepted throughout
module set_assoc_writeback_cache_lru_core #(
  parameter int unsigned SETS = 1024,
  parameter int unsigned WAYS = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [sacl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [sacl_pkg::CfgDataW-1:0] cfg_wdata_i,
  // request channel
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire sacl_pkg::sacl_req_t          in_item_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output sacl_pkg::sacl_rsp_t               out_item_o
);

  import sacl_pkg::*;

  localparam int unsigned SetW   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WayW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RankW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned EntW   = RankW + 2 + TagW;
  localparam int unsigned RowW   = WAYS * EntW;
  localparam int unsigned WideW  = IdxW + 17;
  localparam bit          NeedMod = (SETS < 1024) && ((SETS & (SETS - 1)) != 0);
  // reciprocal of SETS, exact for every index below 1024 when SETS is below 1024
  localparam int unsigned RecipShift = IdxW + 10;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned ProdW      = IdxW + RecipW;
  localparam logic [RecipW-1:0] Recip = RecipW'(((1 << RecipShift) + SETS - 1) / SETS);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;

  logic [2:0] state_q, state_d;

  // configuration registers
  logic [CfgDataW-1:0] offset_bits_q, index_bits_q, ways_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= OffsetBitsRst;
      index_bits_q  <= IndexBitsRst;
      ways_in_use_q <= WaysInUseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOffsetBits: offset_bits_q <= cfg_wdata_i;
        CfgIndexBits:  index_bits_q  <= cfg_wdata_i;
        CfgWaysInUse:  ways_in_use_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [CfgDataW-1:0] ob, ib;
  logic [ShiftW-1:0]   tag_shift;
  logic [WayCntW-1:0]  nways;
  logic [IdxW-1:0]     idx_mask;

  always_comb begin
    ob = (offset_bits_q > MaxOffsetBits) ? MaxOffsetBits : offset_bits_q;
    ib = (index_bits_q > MaxIndexBits) ? MaxIndexBits : index_bits_q;
    tag_shift = ShiftW'(ob) + ShiftW'(ib);
    nways = WayCntW'(ways_in_use_q);
    if (nways == '0) begin
      nways = WayCntW'(1);
    end else if (nways > WayCntW'(WAYS)) begin
      nways = WayCntW'(WAYS);
    end
    idx_mask = IdxW'((11'd1 << ib) - 11'd1);
  end

  // address split of the incoming item
  logic [IdxW-1:0]  in_idx;
  logic [TagW-1:0]  in_tag;
  logic [WideW-1:0] in_idx_ext;
  logic [SetW-1:0]  in_set;

  always_comb begin
    in_idx     = IdxW'(in_item_i.address >> ob) & idx_mask;
    in_tag     = in_item_i.address >> tag_shift;
    in_idx_ext = WideW'(in_idx);
    in_set     = (SETS == 1) ? '0 : in_idx_ext[SetW-1:0];
  end

  // request registers
  logic            is_write_q;
  logic [IdxW-1:0] idx_q;
  logic [TagW-1:0] tag_q;
  logic [SetW-1:0] set_q, set_d;
  logic [IdxW-1:0] rem_q, rem_d;
  logic [IdxW-1:0] quo_q, quo_d;
  logic            mod_ph_q, mod_ph_d;
  logic [WayW-1:0] way_q, way_d;
  logic [SetW-1:0] clr_q, clr_d;

  // set index wrap: quotient by reciprocal multiply, then multiply back and subtract
  logic [ProdW-1:0] quo_prod;
  logic [IdxW-1:0]  quo_next;
  logic [ProdW-1:0] back_prod;
  logic [IdxW-1:0]  rem_next;
  logic [WideW-1:0] rem_next_ext;

  always_comb begin
    quo_prod     = ProdW'(rem_q) * ProdW'(Recip);
    quo_next     = IdxW'(quo_prod >> RecipShift);
    back_prod    = ProdW'(quo_q) * ProdW'(SETS);
    rem_next     = rem_q - back_prod[IdxW-1:0];
    rem_next_ext = WideW'(rem_next);
  end

  // set row store
  logic            ram_we, ram_re;
  logic [SetW-1:0] ram_waddr;
  logic [RowW-1:0] ram_wdata, rd_row;

  sacl_set_ram #(
    .Depth(SETS),
    .Width(RowW)
  ) u_set_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(set_q),
    .rdata_o(rd_row)
  );

  // row fields, per way
  logic             ent_valid [WAYS];
  logic             ent_dirty [WAYS];
  logic [TagW-1:0]  ent_tag   [WAYS];
  logic [RankW-1:0] ent_rank  [WAYS];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      ent_rank[w]  = rd_row[w*EntW +: RankW];
      ent_dirty[w] = rd_row[w*EntW + RankW];
      ent_valid[w] = rd_row[w*EntW + RankW + 1];
      ent_tag[w]   = rd_row[w*EntW + RankW + 2 +: TagW];
    end
  end

  // shared way compare unit
  logic            scan_hit;
  logic [WayW-1:0] hit_way, vic_way;

  sacl_way_cmp #(
    .WayW (WayW),
    .RankW(RankW)
  ) u_way_cmp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == S_READ),
    .step_i   (state_q == S_SCAN),
    .way_i    (way_q),
    .valid_i  (ent_valid[way_q]),
    .tag_i    (ent_tag[way_q]),
    .rank_i   (ent_rank[way_q]),
    .req_tag_i(tag_q),
    .hit_o    (scan_hit),
    .hit_way_o(hit_way),
    .vic_way_o(vic_way)
  );

  // outcome of the scan
  logic [WayW-1:0]    chosen;
  logic [RankW-1:0]   ch_rank;
  logic               wb_needed;
  logic [AddrW-1:0]   wb_addr;
  logic [WayCntW-1:0] chosen_ext;
  logic [WayCntW-1:0] last_way;

  always_comb begin
    chosen     = scan_hit ? hit_way : vic_way;
    ch_rank    = ent_rank[chosen];
    wb_needed  = !scan_hit && ent_valid[vic_way] && ent_dirty[vic_way];
    wb_addr    = '0;
    if (wb_needed) begin
      wb_addr = (ent_tag[vic_way] << tag_shift) | (AddrW'(idx_q) << ob);
    end
    chosen_ext = WayCntW'(chosen);
    last_way   = nways - WayCntW'(1);
  end

  // updated row: promote the chosen way, age those ranked below it
  logic [RowW-1:0] new_row, clr_row;

  always_comb begin
    new_row = rd_row;
    clr_row = '0;
    for (int w = 0; w < WAYS; w++) begin
      clr_row[w*EntW +: RankW] = RankW'(w);
      if (WayCntW'(w) < nways) begin
        if (WayW'(w) == chosen) begin
          new_row[w*EntW +: RankW] = '0;
          if (scan_hit) begin
            new_row[w*EntW + RankW] = ent_dirty[w] | is_write_q;
          end else begin
            new_row[w*EntW + RankW]             = is_write_q;
            new_row[w*EntW + RankW + 1]         = 1'b1;
            new_row[w*EntW + RankW + 2 +: TagW] = tag_q;
          end
        end else if (ent_rank[w] < ch_rank) begin
          new_row[w*EntW +: RankW] = ent_rank[w] + RankW'(1);
        end
      end
    end
  end

  // result register
  logic      out_valid_q, out_valid_d;
  sacl_rsp_t out_item_q;
  logic      out_free;
  logic      in_accept;
  logic      upd_fire;

  assign out_free  = !out_valid_q || out_ready_i;
  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign upd_fire  = (state_q == S_UPD) && out_free;

  // sequencer
  always_comb begin
    state_d     = state_q;
    set_d       = set_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    mod_ph_d    = mod_ph_q;
    way_d       = way_q;
    clr_d       = clr_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = set_q;
    ram_wdata   = new_row;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = clr_row;
        clr_d     = clr_q + SetW'(1);
        if (clr_q == SetW'(SETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          set_d    = in_set;
          rem_d    = in_idx;
          mod_ph_d = 1'b0;
          state_d  = NeedMod ? S_MOD : S_READ;
        end
      end
      S_MOD: begin
        if (!mod_ph_q) begin
          quo_d    = quo_next;
          mod_ph_d = 1'b1;
        end else begin
          set_d   = rem_next_ext[SetW-1:0];
          state_d = S_READ;
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        way_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        way_d = way_q + WayW'(1);
        if (WayCntW'(way_q) == last_way) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (out_free) begin
          ram_we      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q    <= set_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    mod_ph_q <= mod_ph_d;
    way_q    <= way_d;
    if (in_accept) begin
      is_write_q <= (in_item_i.req_type == ReqWrite);
      idx_q      <= in_idx;
      tag_q      <= in_tag;
    end
    if (upd_fire) begin
      out_item_q.hit               <= scan_hit;
      out_item_q.fetch_needed      <= !scan_hit;
      out_item_q.writeback_needed  <= wb_needed;
      out_item_q.writeback_address <= wb_addr;
      out_item_q.way_used          <= chosen_ext[WayUsedW-1:0];
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== tb/set_assoc_writeback_cache_lru_core_tb.sv =====
`timescale 1ns / 100ps

module set_assoc_writeback_cache_lru_core_tb;
  import sacl_pkg::*;

  localparam int unsigned NumSets      = 1024;
  localparam int unsigned NumWays      = 8;
  localparam int unsigned NumLines     = NumSets * NumWays;
  localparam int unsigned LatencySlack = 20;     // wait after the last result, above the longest item with margin
  localparam int unsigned HoldCycles   = 400;    // long receiver hold-off
  localparam int unsigned StallLimit   = 20000;  // covers the clearing pass after reset

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CfgOffsetBits;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  sacl_req_t in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  sacl_rsp_t out_item_o;

  set_assoc_writeback_cache_lru_core #(
    .SETS (NumSets),
    .WAYS (NumWays)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the cache state and registers
  logic        line_present  [NumLines];
  logic        line_modified [NumLines];
  logic [31:0] line_tag_q    [NumLines];
  logic [2:0]  line_age      [NumLines];
  logic [CfgDataW-1:0] m_offset_bits = OffsetBitsRst;
  logic [CfgDataW-1:0] m_index_bits  = IndexBitsRst;
  logic [CfgDataW-1:0] m_ways        = WaysInUseRst;

  sacl_req_t req_backlog  [$];
  sacl_rsp_t rsp_expected [$];

  int unsigned n_pushed      = 0;
  int unsigned n_checked     = 0;
  int unsigned n_errors      = 0;
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 82;
  int unsigned hold_reqs     = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_cycles  = 0;

  function automatic int unsigned eff_offset();
    return (m_offset_bits > MaxOffsetBits) ? MaxOffsetBits : m_offset_bits;
  endfunction

  function automatic int unsigned eff_index();
    return (m_index_bits > MaxIndexBits) ? MaxIndexBits : m_index_bits;
  endfunction

  // lookup, victim choice and lru update for one request
  function automatic sacl_rsp_t cache_lookup(input sacl_req_t req);
    int unsigned ob, ib, nways, base, w, chosen;
    logic [31:0] idx, tag;
    logic [2:0]  r;
    sacl_rsp_t   rsp;
    ob     = eff_offset();
    ib     = eff_index();
    nways  = m_ways;
    if (nways < 1) nways = 1;
    if (nways > NumWays) nways = NumWays;
    idx    = (req.address >> ob) & ((32'd1 << ib) - 32'd1);
    tag    = req.address >> (ob + ib);
    base   = (idx % NumSets) * NumWays;
    rsp    = '0;
    chosen = 0;
    for (w = 0; w < nways; w++) begin
      if (!rsp.hit && line_present[base+w] && line_tag_q[base+w] == tag) begin
        rsp.hit = 1'b1;
        chosen  = w;
      end
    end
    if (rsp.hit) begin
      if (req.req_type == ReqWrite) line_modified[base+chosen] = 1'b1;
    end else begin
      // oldest way wins, lowest number on a tie
      for (w = 1; w < nways; w++) begin
        if (line_age[base+w] > line_age[base+chosen]) chosen = w;
      end
      if (line_present[base+chosen] && line_modified[base+chosen]) begin
        rsp.writeback_needed  = 1'b1;
        rsp.writeback_address = (line_tag_q[base+chosen] << (ob + ib)) | (idx << ob);
      end
      line_tag_q[base+chosen]    = tag;
      line_present[base+chosen]  = 1'b1;
      line_modified[base+chosen] = (req.req_type == ReqWrite);
    end
    r = line_age[base+chosen];
    for (w = 0; w < nways; w++) begin
      if (w != chosen && line_age[base+w] < r) line_age[base+w] = line_age[base+w] + 3'd1;
    end
    line_age[base+chosen] = 3'd0;
    rsp.fetch_needed = !rsp.hit;
    rsp.way_used     = chosen[WayUsedW-1:0];
    return rsp;
  endfunction

  // mostly a small pool of tags and sets so that hits and evictions happen
  function automatic logic [31:0] pick_address();
    int unsigned ob, ib;
    logic [31:0] tag, idx, off;
    ob = eff_offset();
    ib = eff_index();
    if ($urandom_range(0, 99) < 8) return $urandom;
    idx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom;
    tag = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 9) : $urandom;
    off = $urandom;
    return (tag << (ob + ib)) | ((idx & ((32'd1 << ib) - 32'd1)) << ob)
         | (off & ((32'd1 << ob) - 32'd1));
  endfunction

  task automatic push_req(input logic kind, input logic [31:0] addr);
    sacl_req_t req;
    req.req_type = kind;
    req.address  = addr;
    req_backlog.push_back(req);
    n_pushed++;
  endtask

  task automatic flag_mismatch(input string what, input sacl_rsp_t exp_r,
                               input sacl_rsp_t got_r);
    n_errors++;
    if (n_errors <= 10)
      $display("%s: expected hit=%0b fetch=%0b wb=%0b wb_addr=%08h way=%0d",
               what, exp_r.hit, exp_r.fetch_needed, exp_r.writeback_needed,
               exp_r.writeback_address, exp_r.way_used,
               "  got hit=%0b fetch=%0b wb=%0b wb_addr=%08h way=%0d",
               got_r.hit, got_r.fetch_needed, got_r.writeback_needed,
               got_r.writeback_address, got_r.way_used);
  endtask

  task automatic wait_drained();
    while (n_checked < n_pushed) @(posedge clk_i);
    repeat (LatencySlack) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CfgOffsetBits: m_offset_bits = val;
      CfgIndexBits:  m_index_bits  = val;
      CfgWaysInUse:  m_ways        = val;
      default: ;
    endcase
  endtask

  // one setting of the registers, then a burst of random requests
  task automatic run_phase(input logic [CfgDataW-1:0] ob, input logic [CfgDataW-1:0] ib,
                           input logic [CfgDataW-1:0] nw, input int unsigned n_items,
                           input int unsigned send_pct, input int unsigned recv_pct,
                           input bit with_hold);
    int unsigned k;
    wait_drained();
    write_reg(CfgOffsetBits, ob);
    write_reg(CfgIndexBits, ib);
    write_reg(CfgWaysInUse, nw);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (with_hold) hold_reqs <= hold_reqs + 1;
    for (k = 0; k < n_items; k++) push_req(1'($urandom_range(0, 1)), pick_address());
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) rsp_expected.push_back(cache_lookup(in_item_i));
      if (!in_valid_i || in_ready_o) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= req_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    sacl_rsp_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_checked++;
        if (rsp_expected.size() == 0) begin
          flag_mismatch("unexpected item", '0, out_item_o);
        end else begin
          exp_r = rsp_expected.pop_front();
          if (out_item_o.hit !== exp_r.hit
              || out_item_o.fetch_needed !== exp_r.fetch_needed
              || out_item_o.writeback_needed !== exp_r.writeback_needed
              || out_item_o.writeback_address !== exp_r.writeback_address
              || out_item_o.way_used !== exp_r.way_used)
            flag_mismatch("wrong item", exp_r, out_item_o);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_served != hold_reqs) begin
        hold_served++;
        hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("set_assoc_writeback_cache_lru_core: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NumLines; i++) begin
      line_present[i]  = 1'b0;
      line_modified[i] = 1'b0;
      line_tag_q[i]    = '0;
      line_age[i]      = 3'(i % NumWays);
    end

    // directed part at reset settings: 32-byte blocks, 64 sets, 4 ways
    push_req(ReqRead,  32'h0000_0000);  // cold miss
    push_req(ReqWrite, 32'h0000_0000);  // write hit marks the line dirty
    push_req(ReqWrite, 32'h0000_0800);
    push_req(ReqWrite, 32'h0000_1000);
    push_req(ReqWrite, 32'h0000_1800);
    push_req(ReqRead,  32'h0000_2000);  // evicts the dirty tag 0
    push_req(ReqRead,  32'h0000_0804);  // hit on a filled way
    push_req(ReqWrite, 32'h0000_20BF);  // largest offset
    push_req(ReqRead,  32'hFFFF_FFFF);  // all ones
    push_req(ReqWrite, 32'hFFFF_FFFF);
    push_req(ReqRead,  32'hFFFF_FFE0);
    push_req(ReqWrite, 32'h0000_0FE0);  // same top set, other tags
    push_req(ReqWrite, 32'h0000_17E0);
    push_req(ReqWrite, 32'h0000_1FE0);
    push_req(ReqWrite, 32'h0000_27E0);  // dirty all-ones line written back
    push_req(ReqRead,  32'h0000_0000);
    push_req(ReqRead,  32'h7FFF_F800);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // receiver slow
    run_phase(4'd0,  4'd0,  4'd1,  150, 8, 82, 1'b0);
    run_phase(4'd12, 4'd10, 4'd8,  200, 8, 82, 1'b0);
    run_phase(4'd15, 4'd15, 4'd15, 150, 8, 82, 1'b0);  // out-of-range values clamp
    // sender slow
    run_phase(4'd4,  4'd2,  4'd0,  150, 82, 8, 1'b0);  // zero ways acts as one
    run_phase(4'd3,  4'd1,  4'd8,  200, 82, 8, 1'b0);
    run_phase(4'd6,  4'd3,  4'd2,  200, 82, 8, 1'b1);  // long hold-off, input backs up
    run_phase(4'd2,  4'd4,  4'd3,  150, 82, 8, 1'b0);
    // no idling
    run_phase(4'd12, 4'd0,  4'd8,  150, 0, 0, 1'b0);
    run_phase(4'd0,  4'd10, 4'd5,  150, 0, 0, 1'b0);
    run_phase(4'd5,  4'd6,  4'd4,  200, 0, 0, 1'b0);
    run_phase(4'd7,  4'd2,  4'd8,  150, 0, 0, 1'b0);

    wait_drained();
    if (rsp_expected.size() != 0) begin
      $display("%0d expected items never arrived", rsp_expected.size());
      n_errors += rsp_expected.size();
    end
    if (n_errors == 0) begin
      $display("set_assoc_writeback_cache_lru_core: match");
    end else begin
      $display("set_assoc_writeback_cache_lru_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== set_assoc_writeback_cache_lru_core.f =====
design/sacl_pkg.sv
design/sacl_set_ram.sv
design/sacl_way_cmp.sv
design/set_assoc_writeback_cache_lru_core.sv
tb/set_assoc_writeback_cache_lru_core_tb.sv
